[src/color_negative_pixel_inverter_defines.svh]
// Assertion macros for the colour negative pixel inverter.
`ifndef COLOR_NEGATIVE_PIXEL_INVERTER_DEFINES_SVH
`define COLOR_NEGATIVE_PIXEL_INVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define CNPI_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cnpi: implication check failed");
`define CNPI_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cnpi: next-cycle check failed");
`else
`define CNPI_ASSERT_IMP(lbl, pre, post)
`define CNPI_ASSERT_NXT(lbl, pre, post)
`endif
`endif

[src/cnpi_pkg.sv]
// Shared types and constants of the colour negative pixel inverter.
package cnpi_pkg;

    localparam int DIV_BITS   = 17;
    localparam int LAST_STAGE = 20;

    localparam logic [15:0] GAMMA_ONE = 16'd4096;
    localparam logic [15:0] LOG_BODGE = 16'd22715;
    localparam logic [15:0] EXP_BODGE = 16'd22263;

    typedef enum logic [7:0] {
        REG_BASE_MIN_RED   = 8'd0,
        REG_BASE_MIN_GREEN = 8'd1,
        REG_BASE_MIN_BLUE  = 8'd2,
        REG_LIGHT_OFFSET   = 8'd3,
        REG_GAMMA_GREEN    = 8'd4,
        REG_GAMMA_BLUE     = 8'd5,
        REG_CONTRAST_GAIN  = 8'd6,
        REG_BRIGHTNESS     = 8'd7
    } cnpi_reg_t;

    typedef struct packed {
        logic [15:0]        base_min;
        logic [15:0]        gamma;
        logic [15:0]        light_offset;
        logic signed [31:0] contrast;
        logic signed [31:0] brightness;
    } cnpi_chan_cfg_t;

endpackage

[src/cnpi_channel.sv]
// One colour channel: divider, log/exp gamma path and postprocess pipeline.
module cnpi_channel
    import cnpi_pkg::*;
#(
    parameter int SAMPLE_MAX = 65535,
    parameter bit USE_GAMMA  = 1'b1
)
(
    input  logic                  clk,
    input  cnpi_chan_cfg_t        cfg,
    input  logic [LAST_STAGE:0]   stage_en,
    input  logic [15:0]           sample_in,
    output logic [15:0]           sample_out
);

    localparam int          DARK_LEVEL = (SAMPLE_MAX + 999) / 1000;
    localparam logic [15:0] SMAX       = 16'(SAMPLE_MAX);
    localparam logic [15:0] DARK       = 16'(DARK_LEVEL);

    logic [31:0] rem_reg [0:DIV_BITS-1];
    logic [15:0] den_reg [0:DIV_BITS-1];
    logic [16:0] quo_reg [0:DIV_BITS];
    logic        sat_reg [1:DIV_BITS];
    logic        dark_reg [0:LAST_STAGE-1];
    logic [16:0] vg_final;

    logic [16:0]        vsel;
    logic signed [17:0] diff;
    logic [15:0]        w_next, w_reg;
    logic signed [48:0] prod_reg, bs_reg;
    logic signed [49:0] acc;
    logic signed [33:0] o_val;
    logic [15:0]        out_next, out_reg;

    // stage 0: capture sample, dividend = base * full scale
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            den_reg[0]  <= sample_in;
            rem_reg[0]  <= cfg.base_min * SMAX;
            quo_reg[0]  <= '0;
            dark_reg[0] <= (sample_in < DARK);
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_div
        localparam int BITPOS = DIV_BITS - k;
        logic [32:0] shifted, trial;
        logic        take;
        assign shifted = {17'b0, den_reg[k-1]} << BITPOS;
        assign trial   = {1'b0, rem_reg[k-1]} - shifted;
        assign take    = !trial[32];
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
                quo_reg[k] <= quo_reg[k-1] | (17'(take) << BITPOS);
        end
        if (k < DIV_BITS)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                begin
                    rem_reg[k] <= take ? trial[31:0] : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
        if (k == 1)
        begin : g_sat0
            // quotient needs more than 17 bits: saturate
            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                    sat_reg[k] <= ({1'b0, rem_reg[0]} >= {den_reg[0], 17'b0});
            end
        end
        else
        begin : g_satn
            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                    sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k < LAST_STAGE; k++)
    begin : g_dark
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
                dark_reg[k] <= dark_reg[k-1];
        end
    end

    if (USE_GAMMA)
    begin : g_gamma
        function automatic logic [3:0] lead_pos(input logic [15:0] z);
            logic [3:0] p;
            p = '0;
            for (int i = 1; i < 16; i++)
                if (z[i])
                    p = 4'(i);
            return p;
        endfunction

        // {p, f} is p*65536 + f, the uncorrected Q16 log2
        function automatic logic [19:0] log_base(input logic [15:0] z);
            logic [3:0]  p;
            logic [31:0] s;
            p = lead_pos(z);
            s = {16'b0, z} << (5'd16 - {1'b0, p});
            return {p, s[15:0]};
        endfunction

        logic [19:0]        lbx1_reg, lbb1_reg, lbx2_reg, lbb2_reg, lbx3_reg, lbb3_reg;
        logic [15:0]        hx2_reg, hb2_reg, cx3_reg, cb3_reg;
        logic [32:0]        hx_prod, hb_prod, h2_prod;
        logic [31:0]        cx_prod, cb_prod, e_prod;
        logic [20:0]        lx4, lb4;
        logic signed [21:0] d4_reg;
        logic signed [38:0] gprod;
        logic signed [25:0] y5_reg;
        logic [15:0]        r6_reg, h6_reg, r7;
        logic signed [9:0]  n6_reg, n7_reg, n8_reg;
        logic [16:0]        m7_reg;
        logic [32:0]        t8_reg, t_shift;
        logic signed [10:0] s9;
        logic [10:0]        rsh;
        logic [16:0]        vg_next;
        logic [16:0]        vg_reg [9:DIV_BITS];

        assign hx_prod = lbx1_reg[15:0] * (17'h10000 - {1'b0, lbx1_reg[15:0]});
        assign hb_prod = lbb1_reg[15:0] * (17'h10000 - {1'b0, lbb1_reg[15:0]});
        assign cx_prod = hx2_reg * LOG_BODGE;
        assign cb_prod = hb2_reg * LOG_BODGE;
        assign lx4     = {1'b0, lbx3_reg} + {5'b0, cx3_reg};
        assign lb4     = {1'b0, lbb3_reg} + {5'b0, cb3_reg};
        assign gprod   = d4_reg * $signed({1'b0, cfg.gamma});
        assign h2_prod = y5_reg[15:0] * (17'h10000 - {1'b0, y5_reg[15:0]});
        assign e_prod  = h6_reg * EXP_BODGE;
        assign r7      = r6_reg;
        assign s9      = 11'(n8_reg) - 11'sd16;
        assign rsh     = 11'(-s9);

        always_comb
        begin
            t_shift = t8_reg >> rsh[5:0];
            if (!s9[10])
                vg_next = '1;
            else if (rsh >= 11'd33)
                vg_next = '0;
            else if (t_shift[32:17] != '0)
                vg_next = '1;
            else
                vg_next = t_shift[16:0];
        end

        always_ff @(posedge clk)
        begin
            if (stage_en[1])
            begin
                lbx1_reg <= log_base(den_reg[0]);
                lbb1_reg <= log_base(cfg.base_min);
            end
            if (stage_en[2])
            begin
                hx2_reg  <= hx_prod[31:16];
                hb2_reg  <= hb_prod[31:16];
                lbx2_reg <= lbx1_reg;
                lbb2_reg <= lbb1_reg;
            end
            if (stage_en[3])
            begin
                cx3_reg  <= cx_prod[31:16];
                cb3_reg  <= cb_prod[31:16];
                lbx3_reg <= lbx2_reg;
                lbb3_reg <= lbb2_reg;
            end
            if (stage_en[4])
                d4_reg <= $signed({1'b0, lb4}) - $signed({1'b0, lx4});
            if (stage_en[5])
                y5_reg <= 26'(gprod >>> 12);
            if (stage_en[6])
            begin
                r6_reg <= y5_reg[15:0];
                n6_reg <= y5_reg[25:16];
                h6_reg <= h2_prod[31:16];
            end
            if (stage_en[7])
            begin
                m7_reg <= 17'h10000 + {1'b0, r7} - {1'b0, e_prod[31:16]};
                n7_reg <= n6_reg;
            end
            if (stage_en[8])
            begin
                t8_reg <= m7_reg * SMAX;
                n8_reg <= n7_reg;
            end
            if (stage_en[9])
                vg_reg[9] <= vg_next;
        end

        for (genvar k = 10; k <= DIV_BITS; k++)
        begin : g_vline
            always_ff @(posedge clk)
            begin
                if (stage_en[k])
                    vg_reg[k] <= vg_reg[k-1];
            end
        end

        assign vg_final = vg_reg[DIV_BITS];
    end
    else
    begin : g_nogamma
        assign vg_final = '0;
    end

    // stage 18: pick the ratio, subtract light offset, clamp
    always_comb
    begin
        if (!USE_GAMMA || cfg.gamma == GAMMA_ONE)
            vsel = sat_reg[DIV_BITS] ? '1 : quo_reg[DIV_BITS];
        else if (cfg.base_min == '0)
            vsel = (cfg.gamma != '0) ? '0 : {1'b0, SMAX};
        else
            vsel = vg_final;
        diff = $signed({1'b0, vsel}) - $signed({2'b0, cfg.light_offset});
        if (diff[17])
            w_next = '0;
        else if (diff[16:0] > {1'b0, SMAX})
            w_next = SMAX;
        else
            w_next = diff[15:0];
    end

    // stage 20: rounding, scale back, saturate; dark samples give full scale
    always_comb
    begin
        acc   = prod_reg + bs_reg + 50'sd32768;
        o_val = 34'(acc >>> 16);
        if (dark_reg[LAST_STAGE-1])
            out_next = SMAX;
        else if (o_val < 0)
            out_next = '0;
        else if (o_val > $signed({18'b0, SMAX}))
            out_next = SMAX;
        else
            out_next = o_val[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[18])
            w_reg <= w_next;
        if (stage_en[19])
        begin
            prod_reg <= cfg.contrast * $signed({1'b0, w_reg});
            bs_reg   <= cfg.brightness * $signed({1'b0, SMAX});
        end
        if (stage_en[LAST_STAGE])
            out_reg <= out_next;
    end

    assign sample_out = out_reg;

endmodule

[src/color_negative_pixel_inverter.sv]
// Colour negative inverter top level: config registers, pipeline valids, three channels.
// Turns one RGB film-negative pixel into a positive pixel per clock unless the output
// stalls. Each item passes 21 register stages before out_valid; the depth is set by the
// 17-stage restoring divider that forms base/sample, with the log/exp gamma path for
// green and blue running alongside it. A stalled output only holds the stages that are
// full, so bubbles further up still close and input is taken meanwhile. Configuration
// registers are written through cfg_wen/cfg_index/cfg_wdata; the user must do so only
// while no item is in flight, as the block itself does not enforce it.
`include "color_negative_pixel_inverter_defines.svh"
module color_negative_pixel_inverter
    import cnpi_pkg::*;
#(
    parameter int SAMPLE_MAX = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] red_in,
    input  logic [15:0] green_in,
    input  logic [15:0] blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out
);

    logic [15:0]        base_red_reg, base_green_reg, base_blue_reg, light_reg;
    logic [15:0]        gamma_green_reg, gamma_blue_reg;
    logic signed [31:0] contrast_reg, bright_reg;
    logic [LAST_STAGE:0] valid_reg, stage_en;
    cnpi_chan_cfg_t     cfg_red, cfg_green, cfg_blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_red_reg    <= '0;
            base_green_reg  <= '0;
            base_blue_reg   <= '0;
            light_reg       <= '0;
            gamma_green_reg <= GAMMA_ONE;
            gamma_blue_reg  <= GAMMA_ONE;
            contrast_reg    <= 32'sd65536;
            bright_reg      <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cnpi_reg_t'(cfg_index))
                REG_BASE_MIN_RED:   base_red_reg    <= cfg_wdata[15:0];
                REG_BASE_MIN_GREEN: base_green_reg  <= cfg_wdata[15:0];
                REG_BASE_MIN_BLUE:  base_blue_reg   <= cfg_wdata[15:0];
                REG_LIGHT_OFFSET:   light_reg       <= cfg_wdata[15:0];
                REG_GAMMA_GREEN:    gamma_green_reg <= cfg_wdata[15:0];
                REG_GAMMA_BLUE:     gamma_blue_reg  <= cfg_wdata[15:0];
                REG_CONTRAST_GAIN:  contrast_reg    <= $signed(cfg_wdata);
                REG_BRIGHTNESS:     bright_reg      <= $signed(cfg_wdata);
                default:            ;
            endcase
        end
    end

    assign cfg_red   = '{base_min: base_red_reg, gamma: GAMMA_ONE, light_offset: light_reg,
                         contrast: contrast_reg, brightness: bright_reg};
    assign cfg_green = '{base_min: base_green_reg, gamma: gamma_green_reg,
                         light_offset: light_reg, contrast: contrast_reg,
                         brightness: bright_reg};
    assign cfg_blue  = '{base_min: base_blue_reg, gamma: gamma_blue_reg,
                         light_offset: light_reg, contrast: contrast_reg,
                         brightness: bright_reg};

    // a stage may load when the output drains or some stage at or below it is empty
    for (genvar k = 0; k <= LAST_STAGE; k++)
    begin : g_en
        assign stage_en[k] = out_ready || !(&valid_reg[LAST_STAGE:k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k <= LAST_STAGE; k++)
                if (stage_en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[LAST_STAGE];

    cnpi_channel #(.SAMPLE_MAX(SAMPLE_MAX), .USE_GAMMA(1'b0)) u_red (
        .clk        (clk),
        .cfg        (cfg_red),
        .stage_en   (stage_en),
        .sample_in  (red_in),
        .sample_out (red_out)
    );

    cnpi_channel #(.SAMPLE_MAX(SAMPLE_MAX), .USE_GAMMA(1'b1)) u_green (
        .clk        (clk),
        .cfg        (cfg_green),
        .stage_en   (stage_en),
        .sample_in  (green_in),
        .sample_out (green_out)
    );

    cnpi_channel #(.SAMPLE_MAX(SAMPLE_MAX), .USE_GAMMA(1'b1)) u_blue (
        .clk        (clk),
        .cfg        (cfg_blue),
        .stage_en   (stage_en),
        .sample_in  (blue_in),
        .sample_out (blue_out)
    );

    `CNPI_ASSERT_IMP(a_ready_on_bubble, !valid_reg[0], in_ready)
    `CNPI_ASSERT_NXT(a_accept_fills, in_valid && in_ready, valid_reg[0])
    `CNPI_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(red_out) && $stable(blue_out))

endmodule
